>>> design/assert_macros.svh
// Assertion macros shared by the edit distance engine.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/ed_pkg.sv
// Shared constants and types of the edit distance engine.
package ed_pkg;

  localparam int MAX_LEN  = 256;
  localparam int LEN_W    = $clog2(MAX_LEN + 1);
  localparam int ADDR_W   = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int ROW_DEPTH = MAX_LEN + 1;
  localparam int COST_W   = LEN_W;
  localparam int SYM_W    = 8;
  localparam int KIND_W   = 2;
  localparam int DIST_W   = 9;
  localparam int DIST_MAX = (1 << DIST_W) - 1;
  localparam int SAT_W    = (COST_W > DIST_W) ? COST_W : DIST_W;

  localparam logic [KIND_W-1:0] KIND_FIRST   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SECOND  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_COMPUTE = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_ROW_RD,
    ST_ROW_LD,
    ST_CELL_RD,
    ST_CELL_WR,
    ST_ROW_END,
    ST_DONE
  } ed_state_t;

  typedef struct packed {
    logic             busy;
    logic             row_init;
    logic             row_start;
    logic             cell_wr;
    logic             done;
    logic [LEN_W-1:0] i;
    logic [LEN_W-1:0] j;
  } ed_ctrl_t;

endpackage

>>> design/edit_distance_engine.sv
// Top level of the edit distance engine: string stores, cost row and result register.
//
//   channel  direction  handshake           payload
//   in       input      in_valid/in_stall   in_kind, in_symbol
//   out      output     out_valid/out_stall out_distance, out_overflow
//
// A compute item holds in_stall high while the sequencer walks the table: every
// cell goes through the one cell unit and the single read port of the cost row
// memory, a read state followed by a write state.
// Reset (rst_n low at a clock edge) clears the lengths, the dropped flag, the
// result valid flag and the sequencer; the memories keep their contents, and no
// unwritten word of them is ever used.
// A held result does not block appends; a compute item waits until it is taken.
module edit_distance_engine (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [ed_pkg::KIND_W-1:0] in_kind,
  input  logic [ed_pkg::SYM_W-1:0]  in_symbol,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [ed_pkg::DIST_W-1:0] out_distance,
  output logic                      out_overflow
);
  import ed_pkg::*;

  ed_ctrl_t ctrl;

  logic [LEN_W-1:0]  first_len_r, first_len_nxt;
  logic [LEN_W-1:0]  second_len_r, second_len_nxt;
  logic              drop_r, drop_nxt;
  logic [COST_W-1:0] diag_r, diag_nxt;
  logic [COST_W-1:0] left_r, left_nxt;
  logic [SYM_W-1:0]  sym_a_r, sym_a_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [DIST_W-1:0] out_distance_r, out_distance_nxt;
  logic              out_overflow_r, out_overflow_nxt;

  logic              in_xfer;
  logic              start;
  logic              first_full;
  logic              second_full;
  logic              first_we;
  logic              second_we;
  logic [LEN_W-1:0]  i_m1;
  logic [LEN_W-1:0]  j_m1;
  logic [SYM_W-1:0]  first_rdata;
  logic [SYM_W-1:0]  second_rdata;
  logic              row_we;
  logic [COST_W-1:0] row_wdata;
  logic [COST_W-1:0] row_rdata;
  logic [COST_W-1:0] cell_cost;
  logic [COST_W-1:0] raw_dist;

  assign in_xfer     = in_valid && !in_stall;
  assign in_stall    = ctrl.busy || (out_valid_r && (in_kind == KIND_COMPUTE));
  assign start       = in_xfer && (in_kind == KIND_COMPUTE);
  assign first_full  = (first_len_r >= LEN_W'(MAX_LEN));
  assign second_full = (second_len_r >= LEN_W'(MAX_LEN));
  assign first_we    = in_xfer && (in_kind == KIND_FIRST) && !first_full;
  assign second_we   = in_xfer && (in_kind == KIND_SECOND) && !second_full;
  assign i_m1        = ctrl.i - LEN_W'(1);
  assign j_m1        = ctrl.j - LEN_W'(1);

  ed_ram #(.WIDTH(SYM_W), .DEPTH(MAX_LEN)) u_first_ram (
    .clk   (clk),
    .we    (first_we),
    .waddr (first_len_r[ADDR_W-1:0]),
    .wdata (in_symbol),
    .raddr (i_m1[ADDR_W-1:0]),
    .rdata (first_rdata)
  );

  ed_ram #(.WIDTH(SYM_W), .DEPTH(MAX_LEN)) u_second_ram (
    .clk   (clk),
    .we    (second_we),
    .waddr (second_len_r[ADDR_W-1:0]),
    .wdata (in_symbol),
    .raddr (j_m1[ADDR_W-1:0]),
    .rdata (second_rdata)
  );

  // The row is always addressed by the column counter, which the sequencer
  // holds at zero while it reads the left edge of a new row.
  ed_ram #(.WIDTH(COST_W), .DEPTH(ROW_DEPTH)) u_row_ram (
    .clk   (clk),
    .we    (row_we),
    .waddr (ctrl.j),
    .wdata (row_wdata),
    .raddr (ctrl.j),
    .rdata (row_rdata)
  );

  ed_cell_unit u_cell (
    .up    (row_rdata),
    .left  (left_r),
    .diag  (diag_r),
    .sym_a (sym_a_r),
    .sym_b (second_rdata),
    .cost  (cell_cost)
  );

  ed_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .n1    (first_len_r),
    .n2    (second_len_r),
    .ctrl  (ctrl)
  );

  assign row_we    = ctrl.row_init || ctrl.row_start || ctrl.cell_wr;
  assign row_wdata = ctrl.row_init ? ctrl.j : (ctrl.row_start ? ctrl.i : cell_cost);

  // With an empty first string the answer is the initial row's last entry.
  assign raw_dist = (first_len_r == '0) ? second_len_r : left_r;

  always_comb begin
    first_len_nxt    = first_len_r;
    second_len_nxt   = second_len_r;
    drop_nxt         = drop_r;
    diag_nxt         = diag_r;
    left_nxt         = left_r;
    sym_a_nxt        = sym_a_r;
    out_valid_nxt    = out_valid_r;
    out_distance_nxt = out_distance_r;
    out_overflow_nxt = out_overflow_r;

    if (first_we) begin
      first_len_nxt = first_len_r + LEN_W'(1);
    end
    if (second_we) begin
      second_len_nxt = second_len_r + LEN_W'(1);
    end
    if (in_xfer && (((in_kind == KIND_FIRST) && first_full) ||
                    ((in_kind == KIND_SECOND) && second_full))) begin
      drop_nxt = 1'b1;
    end

    if (ctrl.row_start) begin
      diag_nxt  = row_rdata;
      sym_a_nxt = first_rdata;
      left_nxt  = ctrl.i;
    end else if (ctrl.cell_wr) begin
      diag_nxt = row_rdata;
      left_nxt = cell_cost;
    end

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (ctrl.done) begin
      out_valid_nxt    = 1'b1;
      out_overflow_nxt = drop_r;
      out_distance_nxt = (SAT_W'(raw_dist) > SAT_W'(DIST_MAX)) ?
                         DIST_W'(DIST_MAX) : DIST_W'(raw_dist);
      first_len_nxt    = '0;
      second_len_nxt   = '0;
      drop_nxt         = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_len_r  <= '0;
      second_len_r <= '0;
      drop_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      first_len_r  <= first_len_nxt;
      second_len_r <= second_len_nxt;
      drop_r       <= drop_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    diag_r         <= diag_nxt;
    left_r         <= left_nxt;
    sym_a_r        <= sym_a_nxt;
    out_distance_r <= out_distance_nxt;
    out_overflow_r <= out_overflow_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_distance = out_distance_r;
  assign out_overflow = out_overflow_r;

`include "assert_macros.svh"

  `ASSERT_SAME(a_result_after_compute, $rose(out_valid_r), $past(ctrl.busy), "result without compute")
  `ASSERT_SAME(a_cleared_on_result, $rose(out_valid_r), (first_len_r == '0) && (second_len_r == '0) && !drop_r, "strings not cleared with result")
  `ASSERT_NEXT(a_compute_starts, start, ctrl.busy && !out_valid_r, "compute transfer did not start the sequencer")
  `ASSERT_SAME(a_len_bound, ctrl.busy, (first_len_r <= LEN_W'(MAX_LEN)) && (second_len_r <= LEN_W'(MAX_LEN)), "string length out of range")

endmodule

>>> design/ed_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ed_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> design/ed_cell_unit.sv
// Shared cell update unit: minimum of insert, delete and substitute costs.
module ed_cell_unit (
  input  logic [ed_pkg::COST_W-1:0] up,
  input  logic [ed_pkg::COST_W-1:0] left,
  input  logic [ed_pkg::COST_W-1:0] diag,
  input  logic [ed_pkg::SYM_W-1:0]  sym_a,
  input  logic [ed_pkg::SYM_W-1:0]  sym_b,
  output logic [ed_pkg::COST_W-1:0] cost
);
  import ed_pkg::*;

  // One extra bit keeps cost plus one from wrapping at the largest length.
  logic [COST_W:0] del_c;
  logic [COST_W:0] ins_c;
  logic [COST_W:0] sub_c;
  logic [COST_W:0] min_a;
  logic [COST_W:0] min_b;

  always_comb begin
    del_c = {1'b0, up} + (COST_W+1)'(1);
    ins_c = {1'b0, left} + (COST_W+1)'(1);
    sub_c = {1'b0, diag} + ((sym_a != sym_b) ? (COST_W+1)'(1) : (COST_W+1)'(0));
    min_a = (del_c < ins_c) ? del_c : ins_c;
    min_b = (min_a < sub_c) ? min_a : sub_c;
    cost  = min_b[COST_W-1:0];
  end

endmodule

>>> design/ed_seq.sv
// Sequencer that walks the dynamic-programming row over both strings.
module ed_seq (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [ed_pkg::LEN_W-1:0] n1,
  input  logic [ed_pkg::LEN_W-1:0] n2,
  output ed_pkg::ed_ctrl_t         ctrl
);
  import ed_pkg::*;

  ed_state_t        state_r, state_nxt;
  logic [LEN_W-1:0] i_r, i_nxt;
  logic [LEN_W-1:0] j_r, j_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      i_r     <= '0;
      j_r     <= '0;
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
    end
  end

  // Next state and loop counters.
  always_comb begin
    state_nxt = state_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_INIT;
          j_nxt     = '0;
        end
      end
      ST_INIT: begin
        if (j_r == n2) begin
          state_nxt = (n1 == '0) ? ST_DONE : ST_ROW_RD;
          i_nxt     = LEN_W'(1);
          j_nxt     = '0;
        end else begin
          j_nxt = j_r + LEN_W'(1);
        end
      end
      ST_ROW_RD: begin
        state_nxt = ST_ROW_LD;
      end
      ST_ROW_LD: begin
        state_nxt = (n2 == '0) ? ST_ROW_END : ST_CELL_RD;
        j_nxt     = LEN_W'(1);
      end
      ST_CELL_RD: begin
        state_nxt = ST_CELL_WR;
      end
      ST_CELL_WR: begin
        if (j_r == n2) begin
          state_nxt = ST_ROW_END;
        end else begin
          state_nxt = ST_CELL_RD;
          j_nxt     = j_r + LEN_W'(1);
        end
      end
      ST_ROW_END: begin
        if (i_r == n1) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_ROW_RD;
          i_nxt     = i_r + LEN_W'(1);
          j_nxt     = '0;
        end
      end
      ST_DONE: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control outputs decoded from the state.
  always_comb begin
    ctrl           = '0;
    ctrl.i         = i_r;
    ctrl.j         = j_r;
    ctrl.busy      = (state_r != ST_IDLE);
    case (state_r)
      ST_INIT:    ctrl.row_init  = 1'b1;
      ST_ROW_LD:  ctrl.row_start = 1'b1;
      ST_CELL_WR: ctrl.cell_wr   = 1'b1;
      ST_DONE:    ctrl.done      = 1'b1;
      default:    ctrl.done      = 1'b0;
    endcase
  end

endmodule

>>> bench/edit_distance_engine_tb.sv
// Self-checking testbench of the edit distance engine: string loads, distances and dropped symbols.
module edit_distance_engine_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ed_pkg::*;

  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam int PHASE_ITEMS  = 650;
  localparam int STALL_LIMIT  = 600000;
  localparam int DRAIN_CYCLES = 40;

  typedef enum int {SEQ_PLAIN, SEQ_NOISE, SEQ_SPILL, SEQ_FULL_BOTH} seq_style_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              overflow;
  } result_t;

  // A directed row may carry its result typed in; all other items rely on the predictor.
  typedef struct packed {
    logic              fixed;
    logic [DIST_W-1:0] distance;
    logic              overflow;
  } pinned_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [SYM_W-1:0]  sym;
    logic              fixed;
    logic [DIST_W-1:0] distance;
    logic              overflow;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [KIND_W-1:0] in_kind = '0;
  logic [SYM_W-1:0] in_symbol = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [DIST_W-1:0] out_distance;
  logic out_overflow;

  // Predictor state.
  logic [SYM_W-1:0] first_syms [0:MAX_LEN-1];
  logic [SYM_W-1:0] second_syms [0:MAX_LEN-1];
  int first_count = 0;
  int second_count = 0;
  logic symbols_dropped = 1'b0;

  result_t pending_results[$];
  pinned_t typed_results[$];

  int send_gap_pct = 10;
  int recv_gap_pct = 79;
  int items_sent = 0;
  int ignored_items = 0;
  int results_checked = 0;
  int overflow_results = 0;
  int widest_distance = 0;
  int longest_first = 0;
  int longest_second = 0;
  int fail_count = 0;
  int quiet_cycles = 0;

  stim_row_t directed_rows [0:24];

  edit_distance_engine dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_kind      (in_kind),
    .in_symbol    (in_symbol),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_distance (out_distance),
    .out_overflow (out_overflow)
  );

  always #10 clk = ~clk;

  task automatic flag_failure(input string what);
    fail_count++;
    if (fail_count <= 10) begin
      $display("ERROR at %0t: %s", $realtime, what);
    end
  endtask

  // Levenshtein distance of the loaded strings, one row at a time, saturated to the port.
  function automatic int unsigned loaded_edit_cost();
    int unsigned above [0:MAX_LEN];
    int unsigned here [0:MAX_LEN];
    int unsigned subst;
    int unsigned best;
    int i;
    int j;
    for (j = 0; j <= second_count; j++) above[j] = j;
    for (i = 1; i <= first_count; i++) begin
      here[0] = i;
      for (j = 1; j <= second_count; j++) begin
        subst = above[j-1] + ((first_syms[i-1] != second_syms[j-1]) ? 1 : 0);
        best = (above[j] + 1 < here[j-1] + 1) ? above[j] + 1 : here[j-1] + 1;
        here[j] = (subst < best) ? subst : best;
      end
      above = here;
    end
    return (above[second_count] > DIST_MAX) ? DIST_MAX : above[second_count];
  endfunction

  function automatic logic [SYM_W-1:0] pick_symbol(input bit narrow);
    if (narrow) return 8'h40 + SYM_W'($urandom_range(0, 3));
    return SYM_W'($urandom_range(0, 255));
  endfunction

  // Presents one item from a falling edge and returns at the falling edge after its transfer.
  task automatic send_item(input logic [KIND_W-1:0] kind, input logic [SYM_W-1:0] sym,
                           input logic fixed, input logic [DIST_W-1:0] distance,
                           input logic overflow);
    bit taken;
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    typed_results.insert(typed_results.size(), pinned_t'({fixed, distance, overflow}));
    in_valid <= 1'b1;
    in_kind <= kind;
    in_symbol <= sym;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk);
      taken = !in_stall;
      @(negedge clk);
    end
    items_sent++;
  endtask

  task automatic run_sequence(input seq_style_t style, input int short_len);
    logic [SYM_W-1:0] a_q[$];
    logic [SYM_W-1:0] b_q[$];
    logic [SYM_W-1:0] long_q[$];
    logic [SYM_W-1:0] short_q[$];
    int na;
    int pick;
    bit narrow;
    if (style == SEQ_NOISE) begin
      repeat ($urandom_range(1, 6)) begin
        send_item(KIND_W'($urandom_range(0, 3)), pick_symbol(1'b0), 1'b0, '0, 1'b0);
      end
    end else begin
      case (style)
        SEQ_PLAIN: begin
          narrow = $urandom_range(0, 1);
          na = ($urandom_range(0, 4) == 0) ? $urandom_range(11, 40) : $urandom_range(0, 10);
          repeat (na) a_q.insert(a_q.size(), pick_symbol(narrow));
          if ($urandom_range(0, 1) == 1) begin
            // Second string is an edited copy of the first, so distances stay small.
            foreach (a_q[k]) begin
              pick = $urandom_range(0, 9);
              if (pick != 0) b_q.insert(b_q.size(), (pick == 1) ? pick_symbol(narrow) : a_q[k]);
              if ($urandom_range(0, 9) == 0) b_q.insert(b_q.size(), pick_symbol(narrow));
            end
          end else begin
            repeat ($urandom_range(0, 12)) b_q.insert(b_q.size(), pick_symbol(narrow));
          end
        end
        SEQ_SPILL: begin
          repeat (MAX_LEN + $urandom_range(1, 4)) long_q.insert(long_q.size(), pick_symbol(1'b0));
          repeat (short_len) short_q.insert(short_q.size(), pick_symbol(1'b0));
          if ($urandom_range(0, 1) == 1) begin
            a_q = long_q;
            b_q = short_q;
          end else begin
            a_q = short_q;
            b_q = long_q;
          end
        end
        default: begin
          // Both strings at full length; up to two extra symbols on the first are dropped.
          repeat (MAX_LEN) a_q.insert(a_q.size(), pick_symbol(1'b1));
          foreach (a_q[k]) begin
            b_q.insert(b_q.size(), ($urandom_range(0, 3) == 0) ? pick_symbol(1'b1) : a_q[k]);
          end
          repeat ($urandom_range(0, 2)) a_q.insert(a_q.size(), pick_symbol(1'b0));
        end
      endcase
      while (a_q.size() + b_q.size() != 0) begin
        if ($urandom_range(0, 24) == 0) begin
          send_item(KIND_UNUSED, pick_symbol(1'b0), 1'b0, '0, 1'b0);
        end else if (b_q.size() == 0 || (a_q.size() != 0 && $urandom_range(0, 1) == 1)) begin
          send_item(KIND_FIRST, a_q.pop_front(), 1'b0, '0, 1'b0);
        end else begin
          send_item(KIND_SECOND, b_q.pop_front(), 1'b0, '0, 1'b0);
        end
      end
      send_item(KIND_COMPUTE, pick_symbol(1'b0), 1'b0, '0, 1'b0);
    end
  endtask

  // Follows every accepted input transfer and queues the result of each compute item.
  always @(posedge clk) begin : track_inputs
    pinned_t pin;
    result_t want;
    int unsigned cost;
    if (rst_n && in_valid && !in_stall) begin
      pin = typed_results.pop_front();
      case (in_kind)
        KIND_FIRST: begin
          if (first_count < MAX_LEN) begin
            first_syms[first_count] = in_symbol;
            first_count++;
          end else begin
            symbols_dropped = 1'b1;
          end
        end
        KIND_SECOND: begin
          if (second_count < MAX_LEN) begin
            second_syms[second_count] = in_symbol;
            second_count++;
          end else begin
            symbols_dropped = 1'b1;
          end
        end
        KIND_COMPUTE: begin
          cost = loaded_edit_cost();
          want.distance = pin.fixed ? pin.distance : DIST_W'(cost);
          want.overflow = pin.fixed ? pin.overflow : symbols_dropped;
          pending_results.insert(pending_results.size(), want);
          if (first_count > longest_first) longest_first = first_count;
          if (second_count > longest_second) longest_second = second_count;
          first_count = 0;
          second_count = 0;
          symbols_dropped = 1'b0;
        end
        default: begin
          ignored_items++;
        end
      endcase
    end
  end

  always @(posedge clk) begin : check_results
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        flag_failure($sformatf("result %0d/%0b with no distance pending",
                               out_distance, out_overflow));
      end else begin
        want = pending_results.pop_front();
        if (out_distance !== want.distance || out_overflow !== want.overflow) begin
          flag_failure($sformatf("distance/overflow expected %0d/%0b, got %0d/%0b",
                                 want.distance, want.overflow, out_distance, out_overflow));
        end
        results_checked++;
        if (out_overflow === 1'b1) overflow_results++;
        if (out_distance > widest_distance) widest_distance = out_distance;
      end
    end
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_gap_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
        $display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
        $display("CHECK FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    int r;
    int phase;
    int phase_goal;
    directed_rows = '{
      '{KIND_COMPUTE, 8'h00, 1'b1, 9'd0, 1'b0},
      '{KIND_UNUSED,  8'hFF, 1'b0, 9'd0, 1'b0},
      '{KIND_COMPUTE, 8'h00, 1'b1, 9'd0, 1'b0},
      '{KIND_FIRST,   8'h00, 1'b0, 9'd0, 1'b0},
      '{KIND_COMPUTE, 8'h00, 1'b1, 9'd1, 1'b0},
      '{KIND_SECOND,  8'hFF, 1'b0, 9'd0, 1'b0},
      '{KIND_COMPUTE, 8'hFF, 1'b1, 9'd1, 1'b0},
      '{KIND_FIRST,   8'h00, 1'b0, 9'd0, 1'b0},
      '{KIND_SECOND,  8'h00, 1'b0, 9'd0, 1'b0},
      '{KIND_COMPUTE, 8'h00, 1'b1, 9'd0, 1'b0},
      '{KIND_FIRST,   8'hFF, 1'b0, 9'd0, 1'b0},
      '{KIND_SECOND,  8'h00, 1'b0, 9'd0, 1'b0},
      '{KIND_COMPUTE, 8'h00, 1'b1, 9'd1, 1'b0},
      '{KIND_FIRST,   8'hA5, 1'b0, 9'd0, 1'b0},
      '{KIND_UNUSED,  8'h5A, 1'b0, 9'd0, 1'b0},
      '{KIND_SECOND,  8'hA5, 1'b0, 9'd0, 1'b0},
      '{KIND_COMPUTE, 8'h00, 1'b1, 9'd0, 1'b0},
      '{KIND_FIRST,   8'h61, 1'b0, 9'd0, 1'b0},
      '{KIND_FIRST,   8'h62, 1'b0, 9'd0, 1'b0},
      '{KIND_SECOND,  8'h62, 1'b0, 9'd0, 1'b0},
      '{KIND_SECOND,  8'h61, 1'b0, 9'd0, 1'b0},
      '{KIND_COMPUTE, 8'h00, 1'b1, 9'd2, 1'b0},
      '{KIND_FIRST,   8'h80, 1'b0, 9'd0, 1'b0},
      '{KIND_SECOND,  8'h7F, 1'b0, 9'd0, 1'b0},
      '{KIND_COMPUTE, 8'h55, 1'b0, 9'd0, 1'b0}
    };
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    for (r = 0; r < $size(directed_rows); r++) begin
      send_item(directed_rows[r].kind, directed_rows[r].sym, directed_rows[r].fixed,
                directed_rows[r].distance, directed_rows[r].overflow);
    end

    for (phase = 0; phase < 3; phase++) begin
      send_gap_pct = (phase == 0) ? 10 : (phase == 1) ? 79 : 0;
      recv_gap_pct = (phase == 0) ? 79 : (phase == 1) ? 10 : 0;
      phase_goal = items_sent + PHASE_ITEMS;
      // Each phase opens with one long load that fills a string to its capacity or runs past it.
      case (phase)
        0: run_sequence(SEQ_SPILL, 0);
        1: run_sequence(SEQ_FULL_BOTH, 0);
        default: run_sequence(SEQ_SPILL, $urandom_range(1, 6));
      endcase
      while (items_sent < phase_goal) begin
        run_sequence(($urandom_range(0, 9) < 8) ? SEQ_PLAIN : SEQ_NOISE, 0);
      end
    end
    send_item(KIND_COMPUTE, 8'h00, 1'b0, '0, 1'b0);
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d items (%0d of the unused kind); checked %0d distances, %0d with dropped symbols.",
             items_sent, ignored_items, results_checked, overflow_results);
    $display("Largest distance %0d; longest loads %0d and %0d symbols; %0d failures.",
             widest_distance, longest_first, longest_second, fail_count);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
